// ----- hdl/r3fc_pkg.sv -----
package r3fc_pkg;

  localparam int unsigned CRC_W = 24;
  localparam int unsigned LEN_W = 11;
  localparam int unsigned MSG_W = 12;

  localparam logic [7:0]       PREAMBLE      = 8'hD3;
  localparam logic [7:0]       LEN_HIGH_MASK = 8'hFC;
  localparam logic [LEN_W-1:0] FRAME_EXTRA   = 11'd6;
  localparam logic [CRC_W-1:0] CRC_INIT      = 24'h000000;

  localparam logic [LEN_W-1:0] MSG_HI_BYTE = 11'd3;
  localparam logic [LEN_W-1:0] MSG_LO_BYTE = 11'd4;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LENH = 2'd1,
    PH_LENL = 2'd2,
    PH_BODY = 2'd3
  } phase_t;

  localparam logic [CRC_W-1:0] NIB_TAB [16] = '{
    24'h000000, 24'h864CFB, 24'h8AD50D, 24'h0C99F6,
    24'h93E6E1, 24'h15AA1A, 24'h1933EC, 24'h9F7F17,
    24'hA18139, 24'h27CDC2, 24'h2B5434, 24'hAD18CF,
    24'h3267D8, 24'hB42B23, 24'hB8B2D5, 24'h3EFE2E
  };

endpackage

// ----- hdl/rtcm3_frame_checker_unit.sv -----
// Channel  | handshake                  | payload
// ---------+----------------------------+--------------------------------------------
// byte     | byte_valid / byte_stall    | data_byte[7:0]
// result   | result_valid / result_stall| frame_status, message_number, frame_length
//
// One byte beat per cycle while byte_stall is low: an input register feeds the parser
// and CRC-24Q step, which write the result register; result_valid rises at the edge
// on which the last byte of a frame advances out of the input register.
// The sustained rate is set by the combinational two-nibble CRC step.
// Synchronous reset returns the parser to preamble hunting and empties both registers.
// While a result is held by result_stall, the byte held in the input register waits;
// byte_stall rises only when that register is full and cannot advance.
module rtcm3_frame_checker_unit import r3fc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  output logic             byte_stall,
  input  logic [7:0]       data_byte,
  output logic             result_valid,
  input  logic             result_stall,
  output logic             frame_status,
  output logic [MSG_W-1:0] message_number,
  output logic [LEN_W-1:0] frame_length
);

  logic             held;
  logic [7:0]       held_byte;
  logic             advance;
  logic             accept;

  phase_t           phase, phase_next;
  logic [LEN_W-1:0] byte_count, byte_count_next;
  logic [LEN_W-1:0] record_length, record_length_next;
  logic [CRC_W-1:0] crc, crc_next;
  logic [MSG_W-1:0] msg, msg_next;
  logic             done;

  logic [CRC_W-1:0] crc_prev;
  logic [CRC_W-1:0] crc_step;

  assign advance    = held && (!result_valid || !result_stall);
  assign byte_stall = held && !advance;
  assign accept     = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
    if (accept) begin
      held_byte <= data_byte;
    end
  end

  assign crc_prev = (phase == PH_HUNT) ? CRC_INIT : crc;

  r3fc_crc_step u_crc (
    .crc_prev (crc_prev),
    .data     (held_byte),
    .crc_new  (crc_step)
  );

  always_comb begin
    phase_next         = phase;
    byte_count_next    = byte_count;
    record_length_next = record_length;
    crc_next           = crc;
    msg_next           = msg;
    done               = 1'b0;
    case (phase)
      PH_HUNT: begin
        if (held_byte == PREAMBLE) begin
          crc_next           = crc_step;
          byte_count_next    = 11'd1;
          record_length_next = '0;
          msg_next           = '0;
          phase_next         = PH_LENH;
        end
      end
      PH_LENH: begin
        if ((held_byte & LEN_HIGH_MASK) != 8'h00) begin
          phase_next      = PH_HUNT;
          byte_count_next = '0;
        end else begin
          record_length_next = {1'b0, held_byte[1:0], 8'h00};
          crc_next           = crc_step;
          byte_count_next    = 11'd2;
          phase_next         = PH_LENL;
        end
      end
      PH_LENL: begin
        record_length_next = (record_length | {3'b000, held_byte}) + FRAME_EXTRA;
        crc_next           = crc_step;
        byte_count_next    = 11'd3;
        phase_next         = PH_BODY;
      end
      PH_BODY: begin
        if (byte_count == MSG_HI_BYTE) begin
          msg_next = {held_byte, 4'h0};
        end else if (byte_count == MSG_LO_BYTE) begin
          msg_next = {msg[MSG_W-1:4], held_byte[7:4]};
        end
        crc_next        = crc_step;
        byte_count_next = byte_count + 11'd1;
        if (byte_count_next >= record_length) begin
          done            = 1'b1;
          phase_next      = PH_HUNT;
          byte_count_next = '0;
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      byte_count    <= '0;
      record_length <= '0;
      crc           <= CRC_INIT;
      msg           <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      record_length <= record_length_next;
      crc           <= crc_next;
      msg           <= msg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && done) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (advance && done) begin
      frame_status   <= (crc_next != CRC_INIT);
      message_number <= msg_next;
      frame_length   <= record_length;
    end
  end

`ifndef SYNTHESIS
  a_hunt_count_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HUNT) |-> (byte_count == '0))
    else $error("byte count not clear while hunting");

  a_body_in_frame: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (byte_count >= MSG_HI_BYTE && byte_count < record_length))
    else $error("byte count outside frame during body");

  a_done_gives_result: assert property (@(posedge clk) disable iff (rst)
    (advance && done) |=> (result_valid && phase == PH_HUNT))
    else $error("completed frame did not load a result");

  a_result_length: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (frame_length >= FRAME_EXTRA))
    else $error("result frame length below minimum");
`endif

endmodule

// ----- hdl/r3fc_crc_step.sv -----
module r3fc_crc_step import r3fc_pkg::*; (
  input  logic [CRC_W-1:0] crc_prev,
  input  logic [7:0]       data,
  output logic [CRC_W-1:0] crc_new
);

  logic [CRC_W-1:0] mix;
  logic [CRC_W-1:0] half;

  always_comb begin
    mix     = crc_prev ^ {data, 16'h0000};
    half    = {mix[CRC_W-5:0], 4'h0} ^ NIB_TAB[mix[CRC_W-1:CRC_W-4]];
    crc_new = {half[CRC_W-5:0], 4'h0} ^ NIB_TAB[half[CRC_W-1:CRC_W-4]];
  end

endmodule

// ----- tb/rtcm3_frame_checker_unit_tb.sv -----
`timescale 1ns / 1ps
module rtcm3_frame_checker_unit_tb;
  import r3fc_pkg::*;

  localparam logic FRAME_OK      = 1'b0;
  localparam logic FRAME_CRC_ERR = 1'b1;
  localparam int   HOLD_CYCLES   = 400;
  localparam int   MAX_PAYLOAD   = 1023;

  typedef struct packed {
    logic             status;
    logic [MSG_W-1:0] msg;
    logic [LEN_W-1:0] len;
  } frame_res_t;

  typedef struct {
    logic [7:0] b;
    bit         pin;
    frame_res_t res;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             byte_valid;
  logic             byte_stall;
  logic [7:0]       data_byte;
  logic             result_valid;
  logic             result_stall;
  logic             frame_status;
  logic [MSG_W-1:0] message_number;
  logic [LEN_W-1:0] frame_length;

  rtcm3_frame_checker_unit uut (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .data_byte(data_byte),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .frame_status(frame_status),
    .message_number(message_number),
    .frame_length(frame_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser copy
  phase_t           ph;
  logic [LEN_W-1:0] cnt;
  logic [LEN_W-1:0] rec_len;
  logic [CRC_W-1:0] crc;
  logic [MSG_W-1:0] msg;

  frame_res_t frame_q[$];
  frame_res_t pinned_q[$];
  stim_row_t  stim_rows[$];
  frame_res_t predicted;
  frame_res_t want;

  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;
  int frame_bytes = 0;
  int n_frames = 0;
  int n_bad = 0;
  int max_len = 0;

  function automatic logic [CRC_W-1:0] crc24q_byte(input logic [CRC_W-1:0] c,
                                                   input logic [7:0] b);
    logic [CRC_W:0] t;
    t = {1'b0, c ^ {b, 16'h0000}};
    for (int i = 0; i < 8; i++) begin
      t = t << 1;
      if (t[CRC_W]) t = t ^ 25'h1864CFB;
    end
    return t[CRC_W-1:0];
  endfunction

  function automatic bit frame_step(input logic [7:0] b, output frame_res_t r);
    r = '0;
    case (ph)
      PH_HUNT: begin
        if (b == PREAMBLE) begin
          crc = crc24q_byte(CRC_INIT, b);
          cnt = 11'd1;
          rec_len = '0;
          msg = '0;
          ph = PH_LENH;
        end
        return 1'b0;
      end
      PH_LENH: begin
        if ((b & LEN_HIGH_MASK) != 8'h00) begin
          ph = PH_HUNT;
          cnt = '0;
          return 1'b0;
        end
        rec_len = {1'b0, b[1:0], 8'h00};
        crc = crc24q_byte(crc, b);
        cnt = 11'd2;
        ph = PH_LENL;
        return 1'b0;
      end
      PH_LENL: begin
        rec_len = (rec_len | {3'b000, b}) + FRAME_EXTRA;
        crc = crc24q_byte(crc, b);
        cnt = 11'd3;
        ph = PH_BODY;
        return 1'b0;
      end
      default: begin
        if (cnt == MSG_HI_BYTE) msg = {b, 4'h0};
        else if (cnt == MSG_LO_BYTE) msg[3:0] = b[7:4];
        crc = crc24q_byte(crc, b);
        cnt = cnt + 11'd1;
        if (cnt >= rec_len) begin
          r.status = (crc == '0) ? FRAME_OK : FRAME_CRC_ERR;
          r.msg = msg;
          r.len = rec_len;
          ph = PH_HUNT;
          cnt = '0;
          return 1'b1;
        end
        return 1'b0;
      end
    endcase
  endfunction

  task automatic flag(input string what);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (byte_valid && !byte_stall) begin
        if (frame_step(data_byte, predicted)) begin
          if (pinned_q.size() != 0) predicted = pinned_q.pop_front();
          frame_q.push_back(predicted);
        end
      end
      if (result_valid && !result_stall) begin
        if (frame_q.size() == 0) begin
          flag($sformatf("unexpected result msg %0d len %0d", message_number, frame_length));
        end else begin
          want = frame_q.pop_front();
          n_frames++;
          if (want.status == FRAME_CRC_ERR) n_bad++;
          if (int'(want.len) > max_len) max_len = int'(want.len);
          if (frame_status !== want.status)
            flag($sformatf("frame_status %b, want %b", frame_status, want.status));
          if (message_number !== want.msg)
            flag($sformatf("message_number %h, want %h", message_number, want.msg));
          if (frame_length !== want.len)
            flag($sformatf("frame_length %0d, want %0d", frame_length, want.len));
        end
      end
    end
  end

  initial begin
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  task automatic put_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (byte_stall);
  endtask

  task automatic add_row(input logic [7:0] b, input bit pin, input logic st,
                         input logic [MSG_W-1:0] m, input logic [LEN_W-1:0] l);
    stim_row_t r;
    r.b = b;
    r.pin = pin;
    r.res = {st, m, l};
    stim_rows.push_back(r);
  endtask

  task automatic send_frame(input int plen, input bit corrupt, input bit trunc);
    logic [7:0]       fr[$];
    logic [CRC_W-1:0] c;
    logic [9:0]       pl;
    int               keep;
    int               idx;
    pl = 10'(plen);
    c = CRC_INIT;
    fr.push_back(PREAMBLE);
    fr.push_back({6'b000000, pl[9:8]});
    fr.push_back(pl[7:0]);
    repeat (plen) fr.push_back(8'($urandom_range(255)));
    foreach (fr[k]) c = crc24q_byte(c, fr[k]);
    fr.push_back(c[23:16]);
    fr.push_back(c[15:8]);
    fr.push_back(c[7:0]);
    if (corrupt) begin
      idx = $urandom_range(fr.size() - 1, 3);
      fr[idx] = fr[idx] ^ (8'h01 << $urandom_range(7));
    end
    keep = trunc ? $urandom_range(fr.size() - 1, 1) : fr.size();
    for (int k = 0; k < keep; k++) put_byte(fr[k]);
    frame_bytes += keep;
  endtask

  task automatic run_phase(input int budget);
    int         start;
    int         pick;
    int         plen;
    logic [7:0] b;
    start = frame_bytes;
    while (frame_bytes - start < budget) begin
      pick = $urandom_range(99);
      plen = ($urandom_range(19) == 0) ? $urandom_range(300, 25) : $urandom_range(24);
      if (pick < 70) begin
        send_frame(plen, $urandom_range(9) < 2, 1'b0);
      end else if (pick < 80) begin
        send_frame(plen, 1'b0, 1'b1);
      end else if (pick < 90) begin
        b = 8'($urandom_range(255));
        if ((b & LEN_HIGH_MASK) == 8'h00) b[2] = 1'b1;
        put_byte(PREAMBLE);
        put_byte(b);
      end else begin
        repeat ($urandom_range(6, 1)) put_byte(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    byte_valid <= 1'b0;
    data_byte <= 8'h00;
    ph = PH_HUNT;
    cnt = '0;
    rec_len = '0;
    crc = CRC_INIT;
    msg = '0;

    add_row(8'h00, 0, FRAME_OK, '0, '0);
    add_row(8'hD3, 0, FRAME_OK, '0, '0);
    add_row(8'h04, 0, FRAME_OK, '0, '0);
    add_row(8'hD3, 0, FRAME_OK, '0, '0);
    add_row(8'hFC, 0, FRAME_OK, '0, '0);
    add_row(8'hD3, 0, FRAME_OK, '0, '0);
    add_row(8'hD3, 0, FRAME_OK, '0, '0);
    add_row(8'hD3, 0, FRAME_OK, '0, '0);
    add_row(8'h00, 0, FRAME_OK, '0, '0);
    add_row(8'h00, 0, FRAME_OK, '0, '0);
    add_row(8'h47, 0, FRAME_OK, '0, '0);
    add_row(8'hEA, 0, FRAME_OK, '0, '0);
    add_row(8'h4B, 1, FRAME_OK, 12'h47E, 11'd6);
    add_row(8'hD3, 0, FRAME_OK, '0, '0);
    add_row(8'h00, 0, FRAME_OK, '0, '0);
    add_row(8'h00, 0, FRAME_OK, '0, '0);
    add_row(8'h47, 0, FRAME_OK, '0, '0);
    add_row(8'hEA, 0, FRAME_OK, '0, '0);
    add_row(8'h4C, 1, FRAME_CRC_ERR, 12'h47E, 11'd6);
    add_row(8'hD3, 0, FRAME_OK, '0, '0);
    add_row(8'h00, 0, FRAME_OK, '0, '0);
    add_row(8'h01, 0, FRAME_OK, '0, '0);
    add_row(8'h3E, 0, FRAME_OK, '0, '0);
    add_row(8'h8A, 0, FRAME_OK, '0, '0);
    add_row(8'h00, 0, FRAME_OK, '0, '0);
    add_row(8'hFF, 0, FRAME_OK, '0, '0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].pin) pinned_q.push_back(stim_rows[i].res);
      put_byte(stim_rows[i].b);
    end

    send_idle = 27;
    recv_idle = 67;
    run_phase(230);

    send_idle = 67;
    recv_idle = 27;
    run_phase(230);

    // hold results back so the input side backs up
    send_idle = 0;
    recv_idle = 0;
    hold_left = HOLD_CYCLES;
    run_phase(140);
    send_frame(MAX_PAYLOAD, 1'b0, 1'b0);
    run_phase(140);

    byte_valid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d frame bytes plus noise and broken headers; %0d frames checked,",
             frame_bytes, n_frames);
    $display("%0d of them with CRC errors, longest %0d bytes.", n_bad, max_len);
    if (errors == 0) begin
      $display("rtcm3_frame_checker_unit_tb OK");
    end else begin
      $display("rtcm3_frame_checker_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("rtcm3_frame_checker_unit_tb NOT OK");
    $finish;
  end

endmodule
